[sv/pbag_pkg.sv]
// Shared types, register codes and constant tables for the pixel block to glyph unit.
// No dependencies; imported by the top level, the cell evaluation and the testbench.
package pbag_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_ACROSS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_DOWN   = 3'd4;

  localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [6:0]  RST_BLOCK_WIDTH  = 7'd8;
  localparam logic [6:0]  RST_BLOCK_HEIGHT = 7'd16;
  localparam logic [8:0]  RST_CELLS_ACROSS = 9'd80;
  localparam logic [8:0]  RST_CELLS_DOWN   = 9'd30;

  // Cell counters count up to 256, which marks the area below or right of the grid.
  localparam int CELL_CNT_W = 9;

  localparam int RAMP_LEN = 94;
  localparam logic [8*RAMP_LEN-1:0] RAMP =
    " @B#Q80Rg&D$OEN9bd6MHWA%GpPSq5UZ4K3hXkfmCFaVeoIs2jtJwzynu1YclT7}{Lxiv[]/\\()|?*r^<>+;~!=\",_-'  ";

  typedef enum logic [1:0] {ST_IDLE, ST_MODIFY, ST_EVAL, ST_HOLD} top_st_t;
  typedef enum logic [2:0] {EV_IDLE, EV_DIV, EV_C1, EV_C2, EV_C3, EV_C4, EV_C5} ev_st_t;

  typedef struct packed {
    logic start;
  } eval_ctl_t;

  typedef struct packed {
    logic       done;
    logic [7:0] xterm_code;
    logic [6:0] glyph;
  } eval_res_t;

  function automatic logic [2:0] level_of(input logic [7:0] v);
    logic [2:0] lv;
    if (v < 8'd48) lv = 3'd0;
    else if (v < 8'd115) lv = 3'd1;
    else if (v < 8'd155) lv = 3'd2;
    else if (v < 8'd195) lv = 3'd3;
    else if (v < 8'd235) lv = 3'd4;
    else lv = 3'd5;
    return lv;
  endfunction

  function automatic logic [7:0] cube_val(input logic [2:0] lv);
    logic [7:0] cv;
    case (lv)
      3'd0:    cv = 8'h00;
      3'd1:    cv = 8'h5f;
      3'd2:    cv = 8'h87;
      3'd3:    cv = 8'haf;
      3'd4:    cv = 8'hd7;
      default: cv = 8'hff;
    endcase
    return cv;
  endfunction

  function automatic logic [6:0] ramp_char(input logic [6:0] idx);
    logic [7:0] ch;
    ch = RAMP[8*(RAMP_LEN-1-int'(idx)) +: 8];
    return ch[6:0];
  endfunction

endpackage

[sv/pbag_if.sv]
// Handshake channels of the pixel block to glyph unit: the pixel input and the cell result.
// Depends on nothing; used by the top level.
interface pbag_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_start;
  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface pbag_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] xterm_code;
  logic [6:0] glyph;
  logic [7:0] cell_column;
  logic [7:0] cell_row;
  logic       row_end;
  logic       frame_end;
  modport source (output valid, xterm_code, glyph, cell_column, cell_row, row_end, frame_end,
                  input ready);
  modport sink   (input valid, xterm_code, glyph, cell_column, cell_row, row_end, frame_end,
                  output ready);
endinterface

[sv/pixel_block_to_ansi_glyph_unit.sv]
// Top level of the pixel block to glyph unit: position counters, column sum store,
// cell evaluation and the result register. Depends on pbag_pkg, pbag_if, pbag_ram and
// pbag_cell_eval.
//
// Pixels arrive in raster order on in_ch (valid/ready); frame_start on a word clears the
// position counters before that pixel is counted. Each covered pixel is accepted while
// the sum store is read, and the next cycle adds the pixel and writes the entry back;
// no new pixel is taken meanwhile. Pixels outside the cell grid are accepted without
// leaving idle and leave no trace in the sum store. On a cell's last pixel the three
// sums go through a restoring divider, one quotient bit per cycle, then the colour and
// glyph mapping steps EV_C1 to EV_C5; the cell word then waits in the hold state until
// it moves into the output register on out_ch, and the next pixel can be accepted in
// the same cycle that the word appears there. A word waiting on out_ch does not block
// input: only a second finished cell waits for the receiver to take the first.
// The user must write configuration through cfg_we/cfg_index/cfg_data only while the unit
// is idle; the block does not enforce this. Reset (synchronous, rst_n low) restores the
// register defaults and clears the counters and handshake state; the sum store is not
// cleared, as each cell's first pixel overwrites its entry.
module pixel_block_to_ansi_glyph_unit
  import pbag_pkg::*;
#(
  parameter int MAX_CELLS_ACROSS = 256,
  parameter int MAX_IMAGE_WIDTH  = 4096,
  parameter int MAX_BLOCK_SIDE   = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pbag_pixel_if.sink            in_ch,
  pbag_cell_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = (MAX_CELLS_ACROSS < 256) ? MAX_CELLS_ACROSS : 256;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PC_W   = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int CB_W   = $clog2(MAX_BLOCK_SIDE + 1);
  localparam int SUM_W  = 8 + 2 * $clog2(MAX_BLOCK_SIDE);
  localparam int AREA_W = $clog2(MAX_BLOCK_SIDE * MAX_BLOCK_SIDE + 1);

  logic [12:0] img_w_r;
  logic [6:0]  blk_w_r, blk_h_r;
  logic [8:0]  across_r, down_r;

  logic [PC_W-1:0]       iw;
  logic [CB_W-1:0]       bw, bh;
  logic [CELL_CNT_W-1:0] across, down;

  logic [PC_W-1:0]       pc_r, pc0, pc1;
  logic [CB_W-1:0]       cib_r, cib0, cib1, rib_r, rib0, rib1;
  logic [CELL_CNT_W-1:0] ccol_r, ccol0, ccol1, crow_r, crow0, crow1;
  logic [PC_W:0]         pc_inc;
  logic [CB_W:0]         cib_inc, rib_inc;
  logic                  covered, first, last, row_end0, frame_end0;

  top_st_t st_r, st_nxt;
  logic    acc, ram_re, ram_we, out_load, out_valid_r;

  logic [AW-1:0]    addr_r;
  logic [7:0]       red_r, green_r, blue_r, col_r, row_r;
  logic             first_r, last_r, row_end_r, frame_end_r;
  logic [3*SUM_W-1:0] rd_data, wr_data;
  logic [SUM_W-1:0] sum_red, sum_green, sum_blue;
  logic [2*CB_W-1:0] area_full;

  logic [7:0] o_color_r, o_col_r, o_row_r;
  logic [6:0] o_glyph_r;
  logic       o_row_end_r, o_frame_end_r;

  eval_ctl_t ev_ctl;
  eval_res_t ev_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= RST_IMAGE_WIDTH;
      blk_w_r  <= RST_BLOCK_WIDTH;
      blk_h_r  <= RST_BLOCK_HEIGHT;
      across_r <= RST_CELLS_ACROSS;
      down_r   <= RST_CELLS_DOWN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r  <= cfg_data[12:0];
        CFG_BLOCK_WIDTH:  blk_w_r  <= cfg_data[6:0];
        CFG_BLOCK_HEIGHT: blk_h_r  <= cfg_data[6:0];
        CFG_CELLS_ACROSS: across_r <= cfg_data[8:0];
        CFG_CELLS_DOWN:   down_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Register values brought into their working ranges.
  always_comb begin
    if (img_w_r == '0) iw = PC_W'(1);
    else if (32'(img_w_r) > MAX_IMAGE_WIDTH) iw = PC_W'(MAX_IMAGE_WIDTH);
    else iw = PC_W'(img_w_r);
    if (blk_w_r == '0) bw = CB_W'(1);
    else if (32'(blk_w_r) > MAX_BLOCK_SIDE) bw = CB_W'(MAX_BLOCK_SIDE);
    else bw = CB_W'(blk_w_r);
    if (blk_h_r == '0) bh = CB_W'(1);
    else if (32'(blk_h_r) > MAX_BLOCK_SIDE) bh = CB_W'(MAX_BLOCK_SIDE);
    else bh = CB_W'(blk_h_r);
    across = (32'(across_r) > DEPTH) ? CELL_CNT_W'(DEPTH) : across_r;
    down   = (down_r > 9'd256) ? 9'd256 : down_r;
  end

  always_comb begin
    pc0   = in_ch.frame_start ? '0 : pc_r;
    cib0  = in_ch.frame_start ? '0 : cib_r;
    rib0  = in_ch.frame_start ? '0 : rib_r;
    ccol0 = in_ch.frame_start ? '0 : ccol_r;
    crow0 = in_ch.frame_start ? '0 : crow_r;
    if (pc0 >= iw) pc0 = '0;

    covered    = (ccol0 < across) && (crow0 < down);
    first      = (rib0 == '0) && (cib0 == '0);
    cib_inc    = {1'b0, cib0} + (CB_W + 1)'(1);
    rib_inc    = {1'b0, rib0} + (CB_W + 1)'(1);
    last       = (rib_inc >= {1'b0, bh}) && (cib_inc >= {1'b0, bw});
    row_end0   = ({1'b0, ccol0} + 10'd1) == {1'b0, across};
    frame_end0 = row_end0 && (({1'b0, crow0} + 10'd1) == {1'b0, down});

    cib1  = cib0;
    ccol1 = ccol0;
    rib1  = rib0;
    crow1 = crow0;
    if (ccol0 < across) begin
      if (cib_inc >= {1'b0, bw}) begin
        cib1  = '0;
        ccol1 = ccol0 + CELL_CNT_W'(1);
      end else begin
        cib1 = cib_inc[CB_W-1:0];
      end
    end
    pc_inc = {1'b0, pc0} + (PC_W + 1)'(1);
    pc1    = pc_inc[PC_W-1:0];
    if (pc_inc >= {1'b0, iw}) begin
      pc1   = '0;
      cib1  = '0;
      ccol1 = '0;
      if (crow0 < down) begin
        if (rib_inc >= {1'b0, bh}) begin
          rib1  = '0;
          crow1 = crow0 + CELL_CNT_W'(1);
        end else begin
          rib1 = rib_inc[CB_W-1:0];
        end
      end
    end
  end

  assign acc         = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE);

  always_comb begin
    st_nxt       = st_r;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    ev_ctl.start = 1'b0;
    out_load     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (acc && covered) begin
          ram_re = 1'b1;
          st_nxt = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        ram_we       = 1'b1;
        ev_ctl.start = last_r;
        st_nxt       = last_r ? ST_EVAL : ST_IDLE;
      end
      ST_EVAL: begin
        if (ev_res.done) st_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pc_r        <= '0;
      cib_r       <= '0;
      rib_r       <= '0;
      ccol_r      <= '0;
      crow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (acc) begin
        pc_r   <= pc1;
        cib_r  <= cib1;
        rib_r  <= rib1;
        ccol_r <= ccol1;
        crow_r <= crow1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      addr_r      <= ccol0[AW-1:0];
      red_r       <= in_ch.red;
      green_r     <= in_ch.green;
      blue_r      <= in_ch.blue;
      first_r     <= first;
      last_r      <= last;
      col_r       <= ccol0[7:0];
      row_r       <= crow0[7:0];
      row_end_r   <= row_end0;
      frame_end_r <= frame_end0;
    end
    if (out_load) begin
      o_color_r     <= ev_res.xterm_code;
      o_glyph_r     <= ev_res.glyph;
      o_col_r       <= col_r;
      o_row_r       <= row_r;
      o_row_end_r   <= row_end_r;
      o_frame_end_r <= frame_end_r;
    end
  end

  // The first pixel of a cell overwrites the entry, so stale data is never added.
  always_comb begin
    if (first_r) begin
      sum_red   = SUM_W'(red_r);
      sum_green = SUM_W'(green_r);
      sum_blue  = SUM_W'(blue_r);
    end else begin
      sum_red   = rd_data[3*SUM_W-1:2*SUM_W] + SUM_W'(red_r);
      sum_green = rd_data[2*SUM_W-1:SUM_W] + SUM_W'(green_r);
      sum_blue  = rd_data[SUM_W-1:0] + SUM_W'(blue_r);
    end
    wr_data   = {sum_red, sum_green, sum_blue};
    area_full = bw * bh;
  end

  pbag_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (wr_data),
    .re    (ram_re),
    .raddr (ccol0[AW-1:0]),
    .rdata (rd_data)
  );

  pbag_cell_eval #(
    .SUM_W  (SUM_W),
    .AREA_W (AREA_W)
  ) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ev_ctl),
    .sum_red   (sum_red),
    .sum_green (sum_green),
    .sum_blue  (sum_blue),
    .area      (AREA_W'(area_full)),
    .res       (ev_res)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.xterm_code  = o_color_r;
  assign out_ch.glyph       = o_glyph_r;
  assign out_ch.cell_column = o_col_r;
  assign out_ch.cell_row    = o_row_r;
  assign out_ch.row_end     = o_row_end_r;
  assign out_ch.frame_end   = o_frame_end_r;

  a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> $past(ram_re))
    else $error("sum store written without a preceding read");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    ev_res.done |-> st_r == ST_EVAL)
    else $error("cell evaluation finished while no cell was pending");

  a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_HOLD)
    else $error("result word raised without a finished cell");

  a_start_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ev_ctl.start |=> st_r == ST_EVAL)
    else $error("evaluation started without waiting for it");

endmodule

[sv/pbag_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pbag_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/pbag_cell_eval.sv]
// Cell evaluation: divides the three channel sums by the block area, then maps the
// averages to an xterm-256 colour and a ramp glyph. Depends on pbag_pkg.
module pbag_cell_eval
  import pbag_pkg::*;
#(
  parameter int SUM_W  = 20,
  parameter int AREA_W = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  eval_ctl_t         ctl,
  input  logic [SUM_W-1:0]  sum_red,
  input  logic [SUM_W-1:0]  sum_green,
  input  logic [SUM_W-1:0]  sum_blue,
  input  logic [AREA_W-1:0] area,
  output eval_res_t         res
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  ev_st_t st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;

  logic [SUM_W-1:0]  quo_r [3];
  logic [AREA_W-1:0] rem_r [3];
  logic [AREA_W-1:0] den_r;
  logic [SUM_W-1:0]  quo_nxt [3];
  logic [AREA_W-1:0] rem_nxt [3];
  logic [AREA_W:0]   trial [3];

  logic [7:0]  av_c [3];
  logic [7:0]  av_r [3];
  logic [2:0]  lev_r [3];
  logic [7:0]  cv_r [3];
  logic [9:0]  s_r;
  logic [7:0]  avg_r;
  logic [19:0] d2_r;
  logic [4:0]  gi_r;
  logic [17:0] cerr_r;
  logic [17:0] gerr_r;
  logic [25:0] n93_r;
  logic [30:0] nq_r;
  logic [6:0]  q0_r;
  logic [25:0] prod_r;
  logic [7:0]  color_r;
  logic [6:0]  glyph_r;

  logic [20:0] avg_prod;
  logic [9:0]  dark_span;
  logic [15:0] gi_prod;
  logic [4:0]  gi_c;
  logic [19:0] nval;
  logic [7:0]  gv;
  logic [7:0]  idx;
  logic [6:0]  idx_c;

  function automatic logic [15:0] sqd(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      trial[ch] = {rem_r[ch], quo_r[ch][SUM_W-1]};
      if (trial[ch] >= {1'b0, den_r}) begin
        rem_nxt[ch] = AREA_W'(trial[ch] - {1'b0, den_r});
        quo_nxt[ch] = {quo_r[ch][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[ch] = trial[ch][AREA_W-1:0];
        quo_nxt[ch] = {quo_r[ch][SUM_W-2:0], 1'b0};
      end
      av_c[ch] = (quo_r[ch] > SUM_W'(255)) ? 8'hff : quo_r[ch][7:0];
    end
    avg_prod  = s_r * 11'd683;
    dark_span = 10'd765 - s_r;
    gi_prod   = (avg_r - 8'd3) * 8'd205;
    if (avg_r > 8'd238) gi_c = 5'd23;
    else if (avg_r < 8'd3) gi_c = 5'd0;
    else gi_c = gi_prod[15:11];
    nval = 20'd585225 - d2_r;
    gv   = 8'd8 + 8'({gi_r, 3'b000}) + 8'({gi_r, 1'b0});
    idx  = (n93_r >= prod_r) ? {1'b0, q0_r} + 8'd1 : {1'b0, q0_r};
    idx_c = (idx > 8'd93) ? 7'd93 : idx[6:0];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      EV_IDLE: if (ctl.start) st_nxt = EV_DIV;
      EV_DIV:  if (cnt_r == CNT_W'(SUM_W - 1)) st_nxt = EV_C1;
      EV_C1:   st_nxt = EV_C2;
      EV_C2:   st_nxt = EV_C3;
      EV_C3:   st_nxt = EV_C4;
      EV_C4:   st_nxt = EV_C5;
      EV_C5:   st_nxt = EV_IDLE;
      default: st_nxt = EV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= EV_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == EV_C5);
      if (st_r == EV_DIV) cnt_r <= cnt_r + CNT_W'(1);
      else cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      EV_IDLE: begin
        if (ctl.start) begin
          quo_r[0] <= sum_red;
          quo_r[1] <= sum_green;
          quo_r[2] <= sum_blue;
          for (int ch = 0; ch < 3; ch++) rem_r[ch] <= '0;
          den_r <= area;
        end
      end
      EV_DIV: begin
        for (int ch = 0; ch < 3; ch++) begin
          quo_r[ch] <= quo_nxt[ch];
          rem_r[ch] <= rem_nxt[ch];
        end
      end
      EV_C1: begin
        for (int ch = 0; ch < 3; ch++) begin
          av_r[ch]  <= av_c[ch];
          lev_r[ch] <= level_of(av_c[ch]);
        end
        s_r <= 10'(av_c[0]) + 10'(av_c[1]) + 10'(av_c[2]);
      end
      EV_C2: begin
        avg_r <= avg_prod[18:11];
        d2_r  <= dark_span * dark_span;
        for (int ch = 0; ch < 3; ch++) cv_r[ch] <= cube_val(lev_r[ch]);
      end
      EV_C3: begin
        gi_r   <= gi_c;
        cerr_r <= 18'(sqd(cv_r[0], av_r[0])) + 18'(sqd(cv_r[1], av_r[1]))
                + 18'(sqd(cv_r[2], av_r[2]));
        n93_r  <= nval * 7'd93;
        nq_r   <= nval * 11'd1333;
      end
      EV_C4: begin
        gerr_r <= 18'(sqd(gv, av_r[0])) + 18'(sqd(gv, av_r[1])) + 18'(sqd(gv, av_r[2]));
        q0_r   <= nq_r[29:23];
        prod_r <= ({1'b0, nq_r[29:23]} + 8'd1) * 20'd585225;
      end
      EV_C5: begin
        // The cube colour wins a tie against the grey ramp.
        if (cerr_r <= gerr_r) begin
          color_r <= 8'd16 + 8'(lev_r[0] * 6'd36) + 8'(lev_r[1] * 3'd6) + 8'(lev_r[2]);
        end else begin
          color_r <= 8'd232 + 8'(gi_r);
        end
        glyph_r <= ramp_char(idx_c);
      end
      default: ;
    endcase
  end

  assign res.done       = done_r;
  assign res.xterm_code = color_r;
  assign res.glyph      = glyph_r;

endmodule

[tb/sv/pixel_block_to_ansi_glyph_unit_tb.sv]
// Self-checking testbench for pixel_block_to_ansi_glyph_unit: a directed table, extreme
// configurations and random frames, checked against an in-bench cell predictor.
// Depends on pbag_pkg, pbag_if and the RTL of the unit.
`timescale 1ns / 100ps

module pixel_block_to_ansi_glyph_unit_tb;
  import pbag_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
    logic       typed;
    logic [7:0] typed_color;
    logic [6:0] typed_glyph;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0] xterm_code;
    logic [6:0] glyph;
    logic [7:0] cell_column;
    logic [7:0] cell_row;
    logic       row_end;
    logic       frame_end;
  } cell_word_t;

  localparam int DRAIN_CYCLES = 64;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pbag_pixel_if pix_if ();
  pbag_cell_if  cell_if ();

  pixel_block_to_ansi_glyph_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (pix_if),
    .out_ch   (cell_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pixel_word_t pending_pixels[$];
  cell_word_t  expected_cells[$];
  int          mismatches;
  int          failures;

  // Predictor copy of the registers and position state.
  int unsigned m_image_width, m_block_width, m_block_height, m_cells_across, m_cells_down;
  int unsigned m_sum_r[256], m_sum_g[256], m_sum_b[256];
  int unsigned m_pixel_column, m_col_in_block, m_row_in_block, m_cell_col, m_cell_row;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned cube_level(int unsigned v);
    if (v < 48) return 0;
    if (v < 115) return 1;
    return (v - 35) / 40;
  endfunction

  function automatic int unsigned sq_dist(int unsigned a, int unsigned b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic logic [7:0] xterm_index(int unsigned r, int unsigned g, int unsigned b);
    int unsigned lr, lg, lb, avg, gi, gv, cerr, gerr;
    int unsigned levels[6];
    levels = '{0, 'h5f, 'h87, 'haf, 'hd7, 'hff};
    lr = cube_level(r); lg = cube_level(g); lb = cube_level(b);
    avg = (r + g + b) / 3;
    gi = (avg > 238) ? 23 : ((avg < 3) ? 0 : (avg - 3) / 10);
    gv = 8 + 10 * gi;
    cerr = sq_dist(levels[lr], r) + sq_dist(levels[lg], g) + sq_dist(levels[lb], b);
    gerr = sq_dist(gv, r) + sq_dist(gv, g) + sq_dist(gv, b);
    if (cerr <= gerr) return 8'(16 + 36 * lr + 6 * lg + lb);
    return 8'(232 + gi);
  endfunction

  function automatic logic [6:0] brightness_glyph(int unsigned s);
    int unsigned d, idx;
    logic [7:0] ch;
    d = (s > 765) ? 0 : 765 - s;
    idx = (93 * (585225 - d * d)) / 585225;
    if (idx > 93) idx = 93;
    ch = RAMP[8 * (RAMP_LEN - 1 - idx) +: 8];
    return ch[6:0];
  endfunction

  task automatic predict_cell(input pixel_word_t p);
    int unsigned iw, bw, bh, across, down, area, ar, ag, ab;
    cell_word_t c;
    iw = clamp_to(m_image_width, 1, 4096);
    bw = clamp_to(m_block_width, 1, 64);
    bh = clamp_to(m_block_height, 1, 64);
    across = clamp_to(m_cells_across, 0, 256);
    down = clamp_to(m_cells_down, 0, 256);
    if (p.frame_start) begin
      m_pixel_column = 0; m_col_in_block = 0; m_row_in_block = 0;
      m_cell_col = 0; m_cell_row = 0;
    end
    if (m_pixel_column >= iw) m_pixel_column = 0;
    if (m_cell_col < across && m_cell_row < down) begin
      if (m_row_in_block == 0 && m_col_in_block == 0) begin
        m_sum_r[m_cell_col] = p.red; m_sum_g[m_cell_col] = p.green;
        m_sum_b[m_cell_col] = p.blue;
      end else begin
        m_sum_r[m_cell_col] += p.red; m_sum_g[m_cell_col] += p.green;
        m_sum_b[m_cell_col] += p.blue;
      end
      if (m_row_in_block + 1 >= bh && m_col_in_block + 1 >= bw) begin
        area = bw * bh;
        ar = clamp_to(m_sum_r[m_cell_col] / area, 0, 255);
        ag = clamp_to(m_sum_g[m_cell_col] / area, 0, 255);
        ab = clamp_to(m_sum_b[m_cell_col] / area, 0, 255);
        c.xterm_code = xterm_index(ar, ag, ab);
        c.glyph = brightness_glyph(ar + ag + ab);
        if (p.typed) begin
          c.xterm_code = p.typed_color;
          c.glyph = p.typed_glyph;
        end
        c.cell_column = 8'(m_cell_col);
        c.cell_row = 8'(m_cell_row);
        c.row_end = (m_cell_col + 1 == across);
        c.frame_end = (m_cell_col + 1 == across) && (m_cell_row + 1 == down);
        expected_cells.push_back(c);
      end
    end
    if (m_cell_col < across) begin
      m_col_in_block++;
      if (m_col_in_block >= bw) begin
        m_col_in_block = 0;
        m_cell_col++;
      end
    end
    m_pixel_column++;
    if (m_pixel_column >= iw) begin
      m_pixel_column = 0; m_col_in_block = 0; m_cell_col = 0;
      if (m_cell_row < down) begin
        m_row_in_block++;
        if (m_row_in_block >= bh) begin
          m_row_in_block = 0;
          m_cell_row++;
        end
      end
    end
  endtask

  // The word on the bus carries its typed expectation alongside, in order.
  pixel_word_t typed_inflight[$];

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;
  pixel_word_t next_pixel;

  always @(posedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        next_pixel.red = pix_if.red;
        next_pixel.green = pix_if.green;
        next_pixel.blue = pix_if.blue;
        next_pixel.frame_start = pix_if.frame_start;
        next_pixel.typed = 1'b0;
        if (typed_inflight.size() > 0) begin
          next_pixel.typed = typed_inflight[0].typed;
          next_pixel.typed_color = typed_inflight[0].typed_color;
          next_pixel.typed_glyph = typed_inflight[0].typed_glyph;
          typed_inflight.pop_front();
        end
        predict_cell(next_pixel);
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_if.valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          next_pixel = pending_pixels.pop_front();
          typed_inflight.push_back(next_pixel);
          pix_if.red <= next_pixel.red;
          pix_if.green <= next_pixel.green;
          pix_if.blue <= next_pixel.blue;
          pix_if.frame_start <= next_pixel.frame_start;
          pix_if.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switching between always ready, random and mostly stalled.
  int unsigned stall_mode;
  int unsigned stall_left;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        cell_if.ready <= 1'b1;
      end
      1: begin
        cell_if.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        cell_if.ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  cell_word_t got;
  cell_word_t want;

  always @(posedge clk) begin
    if (rst_n && cell_if.valid && cell_if.ready) begin
      got.xterm_code = cell_if.xterm_code;
      got.glyph = cell_if.glyph;
      got.cell_column = cell_if.cell_column;
      got.cell_row = cell_if.cell_row;
      got.row_end = cell_if.row_end;
      got.frame_end = cell_if.frame_end;
      if (expected_cells.size() == 0) begin
        failures++;
        if (mismatches < 10)
          $display("unexpected cell word: color %0d glyph %0d col %0d row %0d",
                   got.xterm_code, got.glyph, got.cell_column, got.cell_row);
        mismatches++;
      end else begin
        want = expected_cells.pop_front();
        if (got !== want) begin
          failures++;
          if (mismatches < 10)
            $display("cell mismatch: exp color %0d glyph %0d col %0d row %0d re %0b fe %0b, got color %0d glyph %0d col %0d row %0d re %0b fe %0b",
                     want.xterm_code, want.glyph, want.cell_column, want.cell_row,
                     want.row_end, want.frame_end, got.xterm_code, got.glyph,
                     got.cell_column, got.cell_row, got.row_end, got.frame_end);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    case (idx)
      CFG_IMAGE_WIDTH:  m_image_width = val & 'h1fff;
      CFG_BLOCK_WIDTH:  m_block_width = val & 'h7f;
      CFG_BLOCK_HEIGHT: m_block_height = val & 'h7f;
      CFG_CELLS_ACROSS: m_cells_across = val & 'h1ff;
      CFG_CELLS_DOWN:   m_cells_down = val & 'h1ff;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(input int unsigned iw, bw, bh, across, down);
    write_reg(CFG_IMAGE_WIDTH, iw);
    write_reg(CFG_BLOCK_WIDTH, bw);
    write_reg(CFG_BLOCK_HEIGHT, bh);
    write_reg(CFG_CELLS_ACROSS, across);
    write_reg(CFG_CELLS_DOWN, down);
  endtask

  // Pixels that complete no cell may still be in flight, hence the fixed pause.
  task automatic wait_quiet();
    while (pending_pixels.size() != 0 || pix_if.valid) @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_pixel(input logic fs, input logic [7:0] r, g, b);
    pixel_word_t p;
    p.red = r; p.green = g; p.blue = b; p.frame_start = fs;
    p.typed = 1'b0; p.typed_color = '0; p.typed_glyph = '0;
    pending_pixels.push_back(p);
  endtask

  pixel_word_t directed_rows[$];
  int unsigned random_items;

  initial begin
    pixel_word_t row;
    int unsigned iw, bw, bh, across, down, rows, frames, n;

    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    pix_if.valid = 1'b0; pix_if.red = '0; pix_if.green = '0; pix_if.blue = '0;
    pix_if.frame_start = 1'b0;
    cell_if.ready = 1'b0;
    mismatches = 0; failures = 0;
    burst_left = 0; gap_left = 0; stall_mode = 0; stall_left = 0;
    m_image_width = RST_IMAGE_WIDTH; m_block_width = RST_BLOCK_WIDTH;
    m_block_height = RST_BLOCK_HEIGHT; m_cells_across = RST_CELLS_ACROSS;
    m_cells_down = RST_CELLS_DOWN;
    m_pixel_column = 0; m_col_in_block = 0; m_row_in_block = 0;
    m_cell_col = 0; m_cell_row = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: part of the first block row, so no cell may complete yet.
    for (int i = 0; i < 40; i++) queue_pixel(i == 0, 8'hff, 8'hff, 8'hff);
    wait_quiet();

    // Directed: two pixels per row, one covered 1x1 cell per row, three rows of cells.
    set_grid(2, 1, 1, 1, 3);
    directed_rows = '{
      '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'd16,  7'd32},
      '{8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 8'd231, 7'd32},
      '{8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'hff, 8'h00, 8'h00, 1'b0, 1'b1, 8'd196, 7'd74},
      '{8'h00, 8'hff, 8'h00, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'h80, 8'h80, 8'h80, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'h7f, 8'h7f, 8'h7f, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'h00, 8'hff, 8'h00, 1'b1, 1'b0, 8'd0,   7'd0},
      '{8'h55, 8'haa, 8'h55, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'h2f, 8'h30, 8'h72, 1'b1, 1'b0, 8'd0,   7'd0},
      '{8'h00, 8'h00, 8'hff, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'h73, 8'hee, 8'hef, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'h02, 8'h03, 8'h04, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'hf0, 8'hef, 8'hee, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'h01, 8'h01, 8'h01, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'h9b, 8'hc3, 8'heb, 1'b0, 1'b0, 8'd0,   7'd0},
      '{8'h11, 8'h22, 8'h33, 1'b0, 1'b0, 8'd0,   7'd0}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      pending_pixels.push_back(row);
    end
    wait_quiet();

    // Zero block sides act as one; a zero cell count covers nothing.
    set_grid(3, 0, 0, 0, 2);
    for (int i = 0; i < 12; i++) queue_pixel(i == 0, rand_channel(), rand_channel(), rand_channel());
    wait_quiet();

    // Oversized block width saturates at the widest block, with bright pixels.
    set_grid(64, 127, 2, 1, 1);
    for (int i = 0; i < 128; i++) queue_pixel(i == 0, 8'hff, 8'hff, 8'hff);
    wait_quiet();
    // Oversized block height saturates at the tallest block.
    set_grid(1, 1, 100, 1, 1);
    for (int i = 0; i < 64; i++) queue_pixel(i == 0, rand_channel(), rand_channel(), rand_channel());
    wait_quiet();

    // Oversized image width and cell count saturate; columns past the last cell are ignored.
    set_grid(8191, 1, 1, 511, 1);
    for (int i = 0; i < 300; i++) queue_pixel(i == 0, rand_channel(), rand_channel(), rand_channel());
    wait_quiet();

    // Zero image width acts as one; the deepest grid, then rows below it are ignored.
    set_grid(0, 1, 0, 1, 511);
    for (int i = 0; i < 266; i++) queue_pixel(i == 0, rand_channel(), rand_channel(), rand_channel());
    wait_quiet();

    random_items = 0;
    while (random_items < 600) begin
      iw = $urandom_range(1, 24);
      bw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 4);
      bh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 4);
      across = clamp_to(bw, 1, 64);
      across = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
                                           : $urandom_range(0, iw / across);
      down = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 6);
      set_grid(iw, bw, bh, across, down);
      rows = clamp_to(bh, 1, 64) * clamp_to(down, 1, 6) + $urandom_range(0, 2);
      if (rows > 16) rows = 16;
      frames = $urandom_range(1, 2);
      for (int f = 0; f < frames; f++) begin
        n = iw * rows;
        for (int i = 0; i < n; i++) begin
          // Mostly whole frames; now and then a frame restarts midway.
          queue_pixel(i == 0 || $urandom_range(0, 199) == 0,
                      rand_channel(), rand_channel(), rand_channel());
        end
        random_items += n;
      end
      wait_quiet();
    end

    if (failures == 0 && expected_cells.size() == 0) begin
      $display("[pixel_block_to_ansi_glyph_unit] OK");
    end else begin
      $display("[pixel_block_to_ansi_glyph_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[pixel_block_to_ansi_glyph_unit] ERROR");
    $finish;
  end

endmodule
